/* src/rti_pkg.sv */
// rti_pkg: shared widths, register codes and payload types of the ray/triangle test.
// Depends on nothing; every other file imports it.
package rti_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CRD_W     = 32;
  localparam int EDGE_W    = CRD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int LO_W      = 34;
  localparam int TERM_W    = CROSS_W + EDGE_W;
  localparam int SUM_W     = TERM_W + 2;
  localparam int QUO_W     = CRD_W + 1;
  localparam int BARY_W    = FRAC_BITS + 1;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORG_X, CFG_ORG_Y, CFG_ORG_Z, CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CRD_W-1:0] v0_x, v0_y, v0_z;
    logic signed [CRD_W-1:0] v1_x, v1_y, v1_z;
    logic signed [CRD_W-1:0] v2_x, v2_y, v2_z;
  } tri_t;

  typedef struct packed {
    logic                    hit;
    logic                    degenerate;
    logic signed [CRD_W-1:0] dist_t;
    logic [BARY_W-1:0]       bary_u;
    logic [BARY_W-1:0]       bary_v;
  } result_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] det, tn, un, vn;
  } geom_t;

endpackage

/* src/rti_geom.sv */
// rti_geom: six-stage pipeline forming the exact determinant and the three numerators.
// Depends on rti_pkg.
module rti_geom import rti_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  tri_t  tri_i,
  input  ray_t  ray_i,
  output logic  valid_o,
  output geom_t geom_o
);

  localparam int NSTG  = 6;
  localparam int PLO_W = LO_W + 1 + EDGE_W;
  localparam int HI_W  = CROSS_W - LO_W;
  localparam int PHI_W = HI_W + EDGE_W;
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  logic [NSTG-1:0] vld_q;

  // stage 1: edges
  logic signed [EDGE_W-1:0] e1_d [3], e2_d [3], s_d [3], dv_d [3];
  logic signed [EDGE_W-1:0] e1_q [3], e2_q [3], s_q [3], dv_q [3];
  // stage 2: cross products, term by term
  logic signed [PROD_W-1:0] pp_d [3][2], qq_d [3][2], pp_q [3][2], qq_q [3][2];
  logic signed [EDGE_W-1:0] e1_2q [3], e2_2q [3], s_2q [3], dv_2q [3];
  // stage 3: cross vectors
  logic signed [CROSS_W-1:0] cp_d [3], cq_d [3], cp_q [3], cq_q [3];
  logic signed [EDGE_W-1:0]  e1_3q [3], e2_3q [3], s_3q [3], dv_3q [3];
  // stage 4: partial products of the dot products
  logic signed [PLO_W-1:0] plo_d [4][3], plo_q [4][3];
  logic signed [PHI_W-1:0] phi_d [4][3], phi_q [4][3];
  // stage 5: terms
  logic signed [TERM_W-1:0] term_d [4][3], term_q [4][3];
  // stage 6: sums
  geom_t geom_d, geom_q;

  always_comb begin
    logic signed [EDGE_W-1:0] v0 [3];
    logic signed [EDGE_W-1:0] v1 [3];
    logic signed [EDGE_W-1:0] v2 [3];
    logic signed [EDGE_W-1:0] org [3];
    v0[0] = EDGE_W'(tri_i.v0_x); v0[1] = EDGE_W'(tri_i.v0_y); v0[2] = EDGE_W'(tri_i.v0_z);
    v1[0] = EDGE_W'(tri_i.v1_x); v1[1] = EDGE_W'(tri_i.v1_y); v1[2] = EDGE_W'(tri_i.v1_z);
    v2[0] = EDGE_W'(tri_i.v2_x); v2[1] = EDGE_W'(tri_i.v2_y); v2[2] = EDGE_W'(tri_i.v2_z);
    org[0] = EDGE_W'(ray_i.ox); org[1] = EDGE_W'(ray_i.oy); org[2] = EDGE_W'(ray_i.oz);
    dv_d[0] = EDGE_W'(ray_i.dx); dv_d[1] = EDGE_W'(ray_i.dy); dv_d[2] = EDGE_W'(ray_i.dz);
    for (int k = 0; k < 3; k++) begin
      e1_d[k] = v1[k] - v0[k];
      e2_d[k] = v2[k] - v0[k];
      s_d[k]  = org[k] - v0[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pp_d[k][0] = PROD_W'(dv_q[NXT1[k]]) * PROD_W'(e2_q[NXT2[k]]);
      pp_d[k][1] = PROD_W'(dv_q[NXT2[k]]) * PROD_W'(e2_q[NXT1[k]]);
      qq_d[k][0] = PROD_W'(s_q[NXT1[k]]) * PROD_W'(e1_q[NXT2[k]]);
      qq_d[k][1] = PROD_W'(s_q[NXT2[k]]) * PROD_W'(e1_q[NXT1[k]]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cp_d[k] = CROSS_W'(pp_q[k][0]) - CROSS_W'(pp_q[k][1]);
      cq_d[k] = CROSS_W'(qq_q[k][0]) - CROSS_W'(qq_q[k][1]);
    end
  end

  // dots: det = P.e1, tn = Q.e2, un = P.s, vn = Q.d
  always_comb begin
    logic signed [CROSS_W-1:0] opx [4][3];
    logic signed [EDGE_W-1:0]  opc [4][3];
    logic signed [LO_W:0]      lo_s;
    logic signed [HI_W-1:0]    hi_s;
    for (int k = 0; k < 3; k++) begin
      opx[0][k] = cp_q[k]; opc[0][k] = e1_3q[k];
      opx[1][k] = cq_q[k]; opc[1][k] = e2_3q[k];
      opx[2][k] = cp_q[k]; opc[2][k] = s_3q[k];
      opx[3][k] = cq_q[k]; opc[3][k] = dv_3q[k];
    end
    lo_s = '0;
    hi_s = '0;
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        lo_s = $signed({1'b0, opx[j][k][LO_W-1:0]});
        hi_s = $signed(opx[j][k][CROSS_W-1:LO_W]);
        plo_d[j][k] = PLO_W'(lo_s) * PLO_W'(opc[j][k]);
        phi_d[j][k] = PHI_W'(hi_s) * PHI_W'(opc[j][k]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        term_d[j][k] = (TERM_W'(phi_q[j][k]) <<< LO_W) + TERM_W'(plo_q[j][k]);
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] acc [4];
    for (int j = 0; j < 4; j++) begin
      acc[j] = SUM_W'(term_q[j][0]) + SUM_W'(term_q[j][1]) + SUM_W'(term_q[j][2]);
    end
    geom_d.det = acc[0];
    geom_d.tn  = acc[1];
    geom_d.un  = acc[2];
    geom_d.vn  = acc[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    e1_q <= e1_d; e2_q <= e2_d; s_q <= s_d; dv_q <= dv_d;
    pp_q <= pp_d; qq_q <= qq_d;
    e1_2q <= e1_q; e2_2q <= e2_q; s_2q <= s_q; dv_2q <= dv_q;
    cp_q <= cp_d; cq_q <= cq_d;
    e1_3q <= e1_2q; e2_3q <= e2_2q; s_3q <= s_2q; dv_3q <= dv_2q;
    plo_q <= plo_d; phi_q <= phi_d;
    term_q <= term_d;
    geom_q <= geom_d;
  end

  assign valid_o = vld_q[NSTG-1];
  assign geom_o  = geom_q;

endmodule

/* src/rti_div.sv */
// rti_div: pipelined restoring divider, floor(num * 2^FRAC_BITS / den) saturated to 32 bits.
// One quotient bit per stage. Depends on rti_pkg.
module rti_div import rti_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [SUM_W-1:0] num_i,
  input  logic signed [SUM_W-1:0] den_i,
  output logic                    valid_o,
  output logic                    zero_o,
  output logic signed [CRD_W-1:0] quot_o
);

  localparam int AW   = SUM_W + FRAC_BITS;
  localparam int RW   = SUM_W + 1;
  localparam int NSTP = QUO_W;

  // magnitude stage
  logic [AW-1:0]    a_q;
  logic [SUM_W-1:0] bm_q;
  logic             neg_q, zr_q, va_q;

  // step pipeline, index 0 is the entry
  logic [RW-1:0]    r_q   [NSTP+1];
  logic [QUO_W-1:0] q_q   [NSTP+1];
  logic [QUO_W-1:0] lo_q  [NSTP+1];
  logic [SUM_W-1:0] b_q   [NSTP+1];
  logic             ovf_q [NSTP+1];
  logic             ng_q  [NSTP+1];
  logic             z_q   [NSTP+1];
  logic [NSTP:0]    vs_q;

  logic                    vo_q, zo_q;
  logic signed [CRD_W-1:0] res_q;

  always_ff @(posedge clk_i) begin
    a_q   <= AW'(num_i[SUM_W-1] ? SUM_W'(-num_i) : SUM_W'(num_i)) << FRAC_BITS;
    bm_q  <= den_i[SUM_W-1] ? SUM_W'(-den_i) : SUM_W'(den_i);
    neg_q <= num_i[SUM_W-1] ^ den_i[SUM_W-1];
    zr_q  <= (den_i == '0);
  end

  // overflow when the quotient needs more than QUO_W bits
  always_ff @(posedge clk_i) begin
    r_q[0]   <= RW'(a_q[AW-1:QUO_W]);
    ovf_q[0] <= RW'(a_q[AW-1:QUO_W]) >= RW'(bm_q);
    lo_q[0]  <= a_q[QUO_W-1:0];
    q_q[0]   <= '0;
    b_q[0]   <= bm_q;
    ng_q[0]  <= neg_q;
    z_q[0]   <= zr_q;
  end

  for (genvar k = 0; k < NSTP; k++) begin : g_step
    logic [RW-1:0] rs;
    logic          ge;
    assign rs = {r_q[k][RW-2:0], lo_q[k][QUO_W-1-k]};
    assign ge = rs >= RW'(b_q[k]);
    always_ff @(posedge clk_i) begin
      r_q[k+1]   <= ge ? rs - RW'(b_q[k]) : rs;
      q_q[k+1]   <= {q_q[k][QUO_W-2:0], ge};
      lo_q[k+1]  <= lo_q[k];
      b_q[k+1]   <= b_q[k];
      ovf_q[k+1] <= ovf_q[k];
      ng_q[k+1]  <= ng_q[k];
      z_q[k+1]   <= z_q[k];
    end
  end

  // sign fix: floor of a negative quotient steps down when a remainder is left
  logic [QUO_W:0]          mag_m;
  logic signed [CRD_W-1:0] res_d;
  always_comb begin
    mag_m = (QUO_W+1)'(q_q[NSTP]) + (QUO_W+1)'(r_q[NSTP] != '0);
    if (ng_q[NSTP]) begin
      if (ovf_q[NSTP] || mag_m > (QUO_W+1)'(1) << (CRD_W-1)) begin
        res_d = {1'b1, {(CRD_W-1){1'b0}}};
      end else begin
        res_d = CRD_W'(-mag_m);
      end
    end else begin
      if (ovf_q[NSTP] || q_q[NSTP][QUO_W-1:CRD_W-1] != '0) begin
        res_d = {1'b0, {(CRD_W-1){1'b1}}};
      end else begin
        res_d = q_q[NSTP][CRD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    zo_q  <= z_q[NSTP];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vs_q <= '0;
      vo_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vs_q <= {vs_q[NSTP-1:0], va_q};
      vo_q <= vs_q[NSTP];
    end
  end

  assign valid_o = vo_q;
  assign zero_o  = zo_q;
  assign quot_o  = res_q;

endmodule

/* src/ray_triangle_intersect.sv */
// From start to done, an item passes the geometry pipeline, the three dividers and the registered hit test.
// Throughput: one triangle per cycle; busy_o never rises and results cannot be held off.
// The 33 one-bit steps of the three parallel dividers set the depth.
// Reset clears all valid bits and loads ray origin 0, direction (0, 0, 1.0).
// Depends on rti_pkg, rti_geom and rti_div.
module ray_triangle_intersect import rti_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  tri_t                 tri_i,
  output logic                 done_o,
  output result_t              result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CRD_W-1:0]     cfg_wdata_i
);

  localparam logic signed [CRD_W-1:0] ONE = CRD_W'(1) << FRAC_BITS;

  ray_t  ray_q;
  logic  geo_vld;
  geom_t geo;
  logic  dv_t, dv_u, dv_v, zr_t, zr_u, zr_v;
  logic signed [CRD_W-1:0] qt, qu, qv;
  logic    done_q;
  result_t res_q, res_d;

  // The pipeline never stalls, so every start is taken.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Ray registers; codes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q <= '{ox: '0, oy: '0, oz: '0, dx: '0, dy: '0, dz: ONE};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ORG_X: ray_q.ox <= cfg_wdata_i;
        CFG_ORG_Y: ray_q.oy <= cfg_wdata_i;
        CFG_ORG_Z: ray_q.oz <= cfg_wdata_i;
        CFG_DIR_X: ray_q.dx <= cfg_wdata_i;
        CFG_DIR_Y: ray_q.dy <= cfg_wdata_i;
        CFG_DIR_Z: ray_q.dz <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rti_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .tri_i   (tri_i),
    .ray_i   (ray_q),
    .valid_o (geo_vld),
    .geom_o  (geo)
  );

  // Three dividers share the determinant; each flags a zero one, and t's flag marks the result degenerate.
  rti_div u_div_t (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (geo_vld),
    .num_i (geo.tn), .den_i (geo.det),
    .valid_o (dv_t), .zero_o (zr_t), .quot_o (qt)
  );
  rti_div u_div_u (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (geo_vld),
    .num_i (geo.un), .den_i (geo.det),
    .valid_o (dv_u), .zero_o (zr_u), .quot_o (qu)
  );
  rti_div u_div_v (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (geo_vld),
    .num_i (geo.vn), .den_i (geo.det),
    .valid_o (dv_v), .zero_o (zr_v), .quot_o (qv)
  );

  // Hit test on the quantized u and v; zero every value on a miss.
  always_comb begin
    logic signed [CRD_W:0] uv;
    logic                  in_rng;
    uv     = (CRD_W+1)'(qu) + (CRD_W+1)'(qv);
    in_rng = (qu >= 0) && (qv >= 0) && (qu <= ONE) && (qv <= ONE)
             && (uv <= (CRD_W+1)'(ONE));
    res_d            = '0;
    res_d.degenerate = zr_t;
    res_d.hit        = !zr_t && in_rng;
    if (res_d.hit) begin
      res_d.dist_t = qt;
      res_d.bary_u = qu[BARY_W-1:0];
      res_d.bary_v = qv[BARY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_t;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef NO_ASSERTIONS
  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_t == dv_u) && (dv_t == dv_v) && (!dv_t || ((zr_t == zr_u) && (zr_t == zr_v))))
    else $error("divider lanes out of step");
  a_hit_not_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.hit && result_o.degenerate))
    else $error("hit on a degenerate triangle");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.hit) |->
      (result_o.dist_t == '0 && result_o.bary_u == '0 && result_o.bary_v == '0))
    else $error("nonzero values on a miss");
  a_bary_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.hit) |->
      ((BARY_W+1)'(result_o.bary_u) + (BARY_W+1)'(result_o.bary_v) <= (BARY_W+1)'(ONE)))
    else $error("barycentric sum above one");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(dv_t))
    else $error("result without a divided item");
`endif

endmodule
